// ===== rtl/mhpq_pkg.sv =====
// Shared constants, codes and types for the max-heap priority queue.
// No dependencies; imported by the top level and the checker.
package mhpq_pkg;

   // parameter defaults
   localparam int CAPACITY_DEF  = 127;
   localparam int KEY_WIDTH_DEF = 32;

   // fixed field widths
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int TOTAL_W    = 7;
   localparam int RSP_DATA_W = ((VALUE_W + TOTAL_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - VALUE_W - TOTAL_W;

   // item kind on the request side
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // result status
   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP,
      ST_RM_ROOT,
      ST_RM_LAST,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_PLACE,
      ST_REPLY
   } state_type;

endpackage

// ===== rtl/mhpq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/max_heap_priority_queue.sv =====
// Binary max-heap priority queue: top level with sequencer and heap RAM.
// Depends on mhpq_pkg and mhpq_ram.
//
// Keeps up to CAPACITY signed keys in a 1-indexed binary max-heap held in a
// single RAM (one write, one registered read port). An insert item (tuser 0)
// adds tdata as a key and sifts it up; a remove item (tuser 1) returns the
// largest key and sifts the last entry down from the root. One result item
// per request: tuser is the status (done, remove on empty, insert on full),
// tdata carries the removed key (zero otherwise) and the entry total. Items
// are handled one at a time; the RAM read port is the limit. An insert walks
// up and a remove walks down at most log2(CAPACITY+1) - 1 levels; an insert
// into an empty heap, an insert on full and a remove on empty walk no levels.
// The next request can be taken as soon as the result loads, even while
// that result still waits on rsp_tready. No clearing pass is needed after
// reset.
module max_heap_priority_queue #(
   parameter int CAPACITY  = mhpq_pkg::CAPACITY_DEF,
   parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mhpq_pkg::VALUE_W-1:0]     req_tdata,  // [31:0] value
   input  logic                             req_tuser,  // [0] kind
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mhpq_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // [31:0] removed_value,
                                                        // [38:32] entry_total
   output logic [mhpq_pkg::STATUS_W-1:0]    rsp_tuser   // [1:0] status
);

   import mhpq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);  // slot / count width
   localparam int AW = $clog2(CAPACITY);      // RAM address width

   // slot n lives at RAM address n-1
   function automatic logic [AW-1:0] slot_addr(input logic [CW-1:0] slot);
      logic [CW-1:0] a;
      a = slot - CW'(1);
      return a[AW-1:0];
   endfunction

   // control state
   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [CW-1:0]                pos_ff, pos_in;
   logic signed [KEY_WIDTH-1:0]  key_ff, key_in;
   logic signed [KEY_WIDTH-1:0]  left_ff, left_in;
   logic                         l_gt_ff, l_gt_in;
   status_type                   status_ff, status_in;
   logic signed [KEY_WIDTH-1:0]  removed_ff, removed_in;

   // result register
   status_type            rsp_status_ff;
   logic [VALUE_W-1:0]    rsp_removed_ff;
   logic [TOTAL_W-1:0]    rsp_total_ff;

   // RAM port
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [KEY_WIDTH-1:0]  ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [KEY_WIDTH-1:0]  ram_rdata;
   logic signed [KEY_WIDTH-1:0] rd_key;

   // decisions
   logic                 req_acc;
   logic                 req_remove;
   logic                 heap_empty;
   logic                 heap_full;
   logic [CW-1:0]        new_slot;
   logic signed [VALUE_W-1:0]   req_value;
   logic signed [KEY_WIDTH-1:0] req_key;
   logic [CW-1:0]        parent_slot;
   logic                 up_gt;
   logic [CW-1:0]        cnt_dec;
   logic                 rm_has_kids;
   logic [CW:0]          left_slot;
   logic [CW:0]          right_slot;
   logic                 has_right;
   logic                 dn_l_gt;
   logic                 r_gt_l;
   logic                 r_gt_key;
   logic                 go_down;
   logic [CW-1:0]        win_slot;
   logic signed [KEY_WIDTH-1:0] win_key;
   logic [CW:0]          win_left;
   logic                 win_has_left;
   logic                 out_free;
   logic                 out_load;

   mhpq_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_key = ram_rdata;

   // request side
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign req_remove = (req_tuser == KIND_REMOVE);
   assign req_value  = req_tdata;
   assign req_key    = KEY_WIDTH'(req_value);
   assign heap_empty = (count_ff == '0);
   assign heap_full  = (count_ff == CW'(CAPACITY));
   assign new_slot   = count_ff + CW'(1);

   // sift up: parent of the hole, compare key against parent read last cycle
   assign parent_slot = pos_ff >> 1;
   assign up_gt       = key_ff > rd_key;

   // remove: entry count after taking the root
   assign cnt_dec     = count_ff - CW'(1);
   assign rm_has_kids = cnt_dec >= CW'(2);

   // sift down: children of the hole
   assign left_slot  = {pos_ff, 1'b0};
   assign right_slot = left_slot + (CW+1)'(1);
   assign has_right  = right_slot <= {1'b0, count_ff};
   assign dn_l_gt    = rd_key > key_ff;

   // right child data arrives: pick larger child (left on tie), test against key
   assign r_gt_l       = rd_key > left_ff;
   assign r_gt_key     = rd_key > key_ff;
   assign go_down      = r_gt_l ? r_gt_key : l_gt_ff;
   assign win_slot     = r_gt_l ? right_slot[CW-1:0] : left_slot[CW-1:0];
   assign win_key      = r_gt_l ? rd_key : left_ff;
   assign win_left     = {win_slot, 1'b0};
   assign win_has_left = win_left <= {1'b0, count_ff};

   // result hand-off
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign out_load = (state_ff == ST_REPLY) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_remove) begin
                  state_in = heap_empty ? ST_REPLY : ST_RM_ROOT;
               end else if (heap_full || new_slot == CW'(1)) begin
                  state_in = ST_REPLY;
               end else begin
                  state_in = ST_UP;
               end
            end
         end
         ST_UP: begin
            if (!up_gt) begin
               state_in = ST_REPLY;
            end else if (parent_slot == CW'(1)) begin
               state_in = ST_PLACE;
            end else begin
               state_in = ST_UP;
            end
         end
         ST_RM_ROOT: state_in = ST_RM_LAST;
         ST_RM_LAST: state_in = rm_has_kids ? ST_DN_LEFT : ST_REPLY;
         ST_DN_LEFT: begin
            if (has_right) begin
               state_in = ST_DN_RIGHT;
            end else begin
               state_in = dn_l_gt ? ST_PLACE : ST_REPLY;
            end
         end
         ST_DN_RIGHT: begin
            if (!go_down) begin
               state_in = ST_REPLY;
            end else begin
               state_in = win_has_left ? ST_DN_LEFT : ST_PLACE;
            end
         end
         ST_PLACE: state_in = ST_REPLY;
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control; the hole method writes each level once
   always_comb begin
      count_in   = count_ff;
      pos_in     = pos_ff;
      key_in     = key_ff;
      left_in    = left_ff;
      l_gt_in    = l_gt_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      ram_we     = 1'b0;
      ram_waddr  = slot_addr(pos_ff);
      ram_wdata  = key_ff;
      ram_raddr  = slot_addr(parent_slot);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               removed_in = '0;
               status_in  = STATUS_DONE;
               key_in     = req_key;
               if (req_remove) begin
                  if (heap_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     ram_raddr = slot_addr(CW'(1));
                  end
               end else if (heap_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  count_in  = new_slot;
                  pos_in    = new_slot;
                  ram_raddr = slot_addr(new_slot >> 1);
                  // first entry goes straight to the root
                  if (new_slot == CW'(1)) begin
                     ram_we    = 1'b1;
                     ram_waddr = slot_addr(new_slot);
                     ram_wdata = req_key;
                  end
               end
            end
         end
         ST_UP: begin
            ram_we = 1'b1;
            if (up_gt) begin
               // parent moves down into the hole
               ram_wdata = rd_key;
               pos_in    = parent_slot;
               ram_raddr = slot_addr(parent_slot >> 1);
            end
         end
         ST_RM_ROOT: begin
            removed_in = rd_key;
            ram_raddr  = slot_addr(count_ff);
         end
         ST_RM_LAST: begin
            key_in    = rd_key;
            count_in  = cnt_dec;
            pos_in    = CW'(1);
            ram_raddr = slot_addr(CW'(2));
            // a single remaining entry lands in the root at once
            if (cnt_dec == CW'(1)) begin
               ram_we    = 1'b1;
               ram_waddr = slot_addr(CW'(1));
               ram_wdata = rd_key;
            end
         end
         ST_DN_LEFT: begin
            left_in = rd_key;
            l_gt_in = dn_l_gt;
            if (has_right) begin
               ram_raddr = slot_addr(right_slot[CW-1:0]);
            end else begin
               ram_we = 1'b1;
               if (dn_l_gt) begin
                  ram_wdata = rd_key;
                  pos_in    = left_slot[CW-1:0];
               end
            end
         end
         ST_DN_RIGHT: begin
            ram_we = 1'b1;
            if (go_down) begin
               ram_wdata = win_key;
               pos_in    = win_slot;
               ram_raddr = slot_addr(win_left[CW-1:0]);
            end
         end
         ST_PLACE: begin
            ram_we = 1'b1;
         end
         ST_REPLY: begin
         end
         default: begin
         end
      endcase
   end

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      key_ff     <= key_in;
      left_ff    <= left_in;
      l_gt_ff    <= l_gt_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= VALUE_W'(removed_ff);
         rsp_total_ff   <= TOTAL_W'(count_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_total_ff, rsp_removed_ff};

endmodule

// ===== rtl/mhpq_checker.sv =====
// Port-level checks for the max-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and max_heap_priority_queue.
module mhpq_port_checks #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [mhpq_pkg::VALUE_W-1:0]     req_tdata,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mhpq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [mhpq_pkg::STATUS_W-1:0]    rsp_tuser
);

   import mhpq_pkg::*;

   // no result item right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item valid after reset");

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   // remove on empty reports zero value and an empty heap
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_EMPTY |->
         rsp_tdata[VALUE_W-1:0] == '0 && rsp_tdata[VALUE_W +: TOTAL_W] == '0)
      else $error("empty status with nonzero value or total");

   // insert on full reports zero value and a full heap
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_FULL |->
         rsp_tdata[VALUE_W-1:0] == '0 &&
         rsp_tdata[VALUE_W +: TOTAL_W] == TOTAL_W'(CAPACITY))
      else $error("full status with nonzero value or wrong total");

endmodule

bind max_heap_priority_queue mhpq_port_checks #(.CAPACITY(CAPACITY)) u_mhpq_port_checks (.*);
